### rtl/core/npr_pkg.sv
`timescale 1ns / 1ps

package npr_pkg;

  // set size and index widths
  localparam int MAX_POINTS = 65536;
  localparam int CNT_W      = $clog2(MAX_POINTS);
  localparam int IDX_W      = 16;

  // field widths
  localparam int COORD_W   = 32;
  localparam int DIR_W     = 18;
  localparam int DIST_W    = 64;
  localparam int CFG_IDX_W = 3;

  // front pipeline and queue
  localparam int FRONT_STAGES = 7;
  localparam int QDEPTH       = 16;
  localparam int QPTR_W       = $clog2(QDEPTH);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  // one point with its end-of-set flag
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } point_t;

  // classified point handed from front to back
  typedef struct packed {
    point_t              pt;
    logic [DIST_W-1:0]   dist_sq;
  } qentry_t;

endpackage

### rtl/core/npr_front.sv
`timescale 1ns / 1ps

module npr_front
  import npr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 acc,
  input  point_t               in_pt,
  output logic                 push,
  output qentry_t              push_data
);

  // line configuration
  logic signed [COORD_W-1:0] org_r [3];
  logic signed [DIR_W-1:0]   dir_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIR_W'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: org_r[0] <= cfg_wdata;
        REG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        REG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        REG_DIR_X:    dir_r[0] <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Y:    dir_r[1] <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Z:    dir_r[2] <= cfg_wdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids
  logic [FRONT_STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], acc};
    end
  end

  // point carried alongside the maths
  point_t pt_r [FRONT_STAGES];

  always_ff @(posedge clk) begin
    pt_r[0] <= in_pt;
    for (int k = 1; k < FRONT_STAGES; k++) begin
      pt_r[k] <= pt_r[k-1];
    end
  end

  // stage 1: v = p - origin
  logic signed [32:0] v1_r [3];
  logic signed [32:0] v2_r [3];
  logic signed [32:0] v3_r [3];
  logic signed [32:0] v4_r [3];
  logic signed [COORD_W-1:0] p_in [3];

  assign p_in[0] = in_pt.x;
  assign p_in[1] = in_pt.y;
  assign p_in[2] = in_pt.z;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v1_r[i] <= {p_in[i][COORD_W-1], p_in[i]} - {org_r[i][COORD_W-1], org_r[i]};
      v2_r[i] <= v1_r[i];
      v3_r[i] <= v2_r[i];
      v4_r[i] <= v3_r[i];
    end
  end

  // stage 2: v_i * dir_i
  logic signed [50:0] prod_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= v1_r[i] * dir_r[i];
    end
  end

  // stage 3: rounded dot product, t with 16 fraction bits
  logic signed [53:0] dot_c;
  logic signed [37:0] t_r;

  always_comb begin
    dot_c = {{3{prod_r[0][50]}}, prod_r[0]} + {{3{prod_r[1][50]}}, prod_r[1]}
          + {{3{prod_r[2][50]}}, prod_r[2]} + 54'sd32768;
  end

  always_ff @(posedge clk) begin
    t_r <= dot_c[53:16];
  end

  // stage 4: t * dir_i
  logic signed [55:0] tp_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      tp_r[i] <= t_r * dir_r[i];
    end
  end

  // stage 5: w = v - round(t * dir), magnitude and overflow
  logic signed [56:0] rnd_c [3];
  logic signed [40:0] c_c   [3];
  logic signed [41:0] w_c   [3];
  logic        [41:0] mag_c [3];
  logic        [31:0] mag_r [3];
  logic               sat5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_c[i] = {tp_r[i][55], tp_r[i]} + 57'sd32768;
      c_c[i]   = rnd_c[i][56:16];
      w_c[i]   = {{9{v4_r[i][32]}}, v4_r[i]} - {c_c[i][40], c_c[i]};
      mag_c[i] = w_c[i][41] ? 42'(-w_c[i]) : 42'(w_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      mag_r[i] <= mag_c[i][31:0];
    end
    sat5_r <= (|mag_c[0][41:32]) | (|mag_c[1][41:32]) | (|mag_c[2][41:32]);
  end

  // stage 6: squares
  logic [63:0] sq_r [3];
  logic        sat6_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= mag_r[i] * mag_r[i];
    end
    sat6_r <= sat5_r;
  end

  // stage 7: saturating sum
  logic [65:0]       sum_c;
  logic [DIST_W-1:0] dist_r;

  assign sum_c = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};

  always_ff @(posedge clk) begin
    if (sat6_r || (|sum_c[65:64])) begin
      dist_r <= '1;
    end else begin
      dist_r <= sum_c[DIST_W-1:0];
    end
  end

  assign push              = vld_r[FRONT_STAGES-1];
  assign push_data.pt      = pt_r[FRONT_STAGES-1];
  assign push_data.dist_sq = dist_r;

endmodule

### rtl/core/npr_fifo.sv
`timescale 1ns / 1ps

module npr_fifo
  import npr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  input  logic    pop,
  output logic    nonempty,
  output qentry_t head
);

  qentry_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];

endmodule

### rtl/core/npr_back.sv
`timescale 1ns / 1ps

module npr_back
  import npr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_nonempty,
  input  qentry_t                   q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_best_index,
  output logic signed [COORD_W-1:0] out_best_x,
  output logic signed [COORD_W-1:0] out_best_y,
  output logic signed [COORD_W-1:0] out_best_z,
  output logic [DIST_W-1:0]         out_best_dist_sq
);

  // running minimum of the current set
  logic [CNT_W-1:0]  count_r;
  logic [DIST_W-1:0] min_d_r;
  logic [CNT_W-1:0]  min_idx_r;
  point_t            min_pt_r;

  // result register
  logic              out_valid_r;
  logic [CNT_W-1:0]  res_idx_r;
  point_t            res_pt_r;
  logic [DIST_W-1:0] res_d_r;

  logic              take;
  logic [DIST_W-1:0] new_d;
  logic [CNT_W-1:0]  new_idx;
  point_t            new_pt;

  // a last point needs the result register free
  assign q_pop = q_nonempty && (!q_head.pt.last || !out_valid_r || out_ready);

  // first point always wins, later ones only when strictly nearer
  always_comb begin
    take    = (count_r == '0) || (q_head.dist_sq < min_d_r);
    new_d   = take ? q_head.dist_sq : min_d_r;
    new_idx = take ? count_r : min_idx_r;
    new_pt  = take ? q_head.pt : min_pt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      min_d_r   <= '1;
      min_idx_r <= '0;
      min_pt_r  <= '0;
    end else if (q_pop) begin
      if (q_head.pt.last) begin
        count_r   <= '0;
        min_d_r   <= '1;
        min_idx_r <= '0;
        min_pt_r  <= '0;
      end else begin
        min_d_r   <= new_d;
        min_idx_r <= new_idx;
        min_pt_r  <= new_pt;
        if (count_r != CNT_W'(MAX_POINTS - 1)) count_r <= count_r + 1'b1;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_head.pt.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.pt.last) begin
      res_idx_r <= new_idx;
      res_pt_r  <= new_pt;
      res_d_r   <= new_d;
    end
  end

  logic [CNT_W+IDX_W-1:0] idx_ext;

  assign idx_ext          = {{IDX_W{1'b0}}, res_idx_r};
  assign out_valid        = out_valid_r;
  assign out_best_index   = idx_ext[IDX_W-1:0];
  assign out_best_x       = res_pt_r.x;
  assign out_best_y       = res_pt_r.y;
  assign out_best_z       = res_pt_r.z;
  assign out_best_dist_sq = res_d_r;

endmodule

### rtl/core/nearest_point_to_ray_picker.sv
`timescale 1ns / 1ps

// Nearest point to a line. Points stream in on the in_ channel, one beat per
// point, with in_last_point marking the final point of a set. The user must
// set the line through the cfg_ port (origin in Q16.16, direction in Q2.16)
// while idle; the block does not enforce this. Each point's squared distance
// to the line is worked out in a seven-stage front pipeline, queued, and
// folded into a running minimum by the back end. One point is taken per
// cycle while in_ready is high; the rate is set by the front pipeline, which
// issues a point every cycle, and by the combinational minimum compare.
// A result beat on the out_ channel follows the last point of a set: index,
// coordinates and saturated squared distance of the earliest nearest point.
// When out_ready is low, the held result stalls the back end at the next
// last point; the queue of 16 entries then fills and in_ready drops.
// Reset (rst_n low, synchronous) empties the pipeline and queue, starts a new
// set and restores origin (0,0,0) and direction (0,0,1).
module nearest_point_to_ray_picker
  import npr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic                      in_last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_best_index,
  output logic signed [COORD_W-1:0] out_best_x,
  output logic signed [COORD_W-1:0] out_best_y,
  output logic signed [COORD_W-1:0] out_best_z,
  output logic [DIST_W-1:0]         out_best_dist_sq
);

  logic    acc;
  point_t  in_pt;
  logic    push;
  qentry_t push_data;
  logic    pop;
  logic    q_nonempty;
  qentry_t q_head;

  // points in flight or queued, kept within the queue depth
  logic [QPTR_W:0] credit_r;

  assign in_ready = (credit_r < (QPTR_W+1)'(QDEPTH));
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + (QPTR_W+1)'(acc) - (QPTR_W+1)'(pop);
    end
  end

  assign in_pt.x    = in_point_x;
  assign in_pt.y    = in_point_y;
  assign in_pt.z    = in_point_z;
  assign in_pt.last = in_last_point;

  npr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_pt     (in_pt),
    .push      (push),
    .push_data (push_data)
  );

  npr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  npr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_index   (out_best_index),
    .out_best_x       (out_best_x),
    .out_best_y       (out_best_y),
    .out_best_z       (out_best_z),
    .out_best_dist_sq (out_best_dist_sq)
  );

endmodule

### tb/nearest_point_to_ray_picker_tb.sv
`timescale 1ns / 1ps

module nearest_point_to_ray_picker_tb;
  import npr_pkg::*;

  localparam int          CYCLE_LIMIT    = 500000;
  localparam int          SETTLE_CYCLES  = 32;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_POINTS   = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
  localparam logic [COORD_W-1:0]   COORD_MAX     = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0]   COORD_MIN     = 32'h8000_0000;
  localparam logic [COORD_W-1:0]   ONE_Q16       = 32'h0001_0000;

  // one result beat: nearest point of a set
  typedef struct {
    logic [IDX_W-1:0]   index;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [DIST_W-1:0]  dist_sq;
  } best_beat_t;

  // tracks the line, the running minimum of the open set and the beats owed
  class nearest_scoreboard;
    longint             line_org[3];
    longint             line_dir[3];
    int unsigned        set_count;
    logic [DIST_W-1:0]  best_dist;
    int unsigned        best_pos;
    logic [COORD_W-1:0] best_pt[3];
    best_beat_t         pending_best[$];
    int unsigned        errors;
    int unsigned        results_checked;
    int unsigned        points_noted;
    int unsigned        sets_closed;

    function new();
      line_org        = '{0, 0, 0};
      line_dir        = '{0, 0, 65536};
      errors          = 0;
      results_checked = 0;
      points_noted    = 0;
      sets_closed     = 0;
      clear_set();
    endfunction

    function void clear_set();
      set_count = 0;
      best_dist = '1;
      best_pos  = 0;
      best_pt   = '{0, 0, 0};
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        REG_ORIGIN_X: line_org[0] = longint'($signed(data));
        REG_ORIGIN_Y: line_org[1] = longint'($signed(data));
        REG_ORIGIN_Z: line_org[2] = longint'($signed(data));
        REG_DIR_X:    line_dir[0] = longint'($signed(data[DIR_W-1:0]));
        REG_DIR_Y:    line_dir[1] = longint'($signed(data[DIR_W-1:0]));
        REG_DIR_Z:    line_dir[2] = longint'($signed(data[DIR_W-1:0]));
        default: ;
      endcase
    endfunction

    // squared distance of a point to the line, saturating at all ones
    function logic [DIST_W-1:0] line_dist_sq(longint px, longint py, longint pz);
      longint      p[3];
      longint      v[3];
      longint      dot;
      longint      t;
      longint      c;
      longint      w;
      logic [63:0] mag;
      logic [64:0] sum;
      p   = '{px, py, pz};
      dot = 0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        v[i] = p[i] - line_org[i];
        dot += v[i] * line_dir[i];
      end
      // projection length, rounded to Q.16
      t = (dot + 32768) >>> 16;
      for (int i = 0; i < 3; i++) begin
        c   = (t * line_dir[i] + 32768) >>> 16;
        w   = v[i] - c;
        mag = (w < 0) ? -w : w;
        if (mag >= 64'h1_0000_0000) return '1;
        sum = sum + mag * mag;
        if (sum[64]) return '1;
      end
      return sum[63:0];
    endfunction

    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic last);
      logic [DIST_W-1:0] d;
      best_beat_t        beat;
      d = line_dist_sq(longint'($signed(x)), longint'($signed(y)),
                       longint'($signed(z)));
      points_noted++;
      // first point always taken, ties keep the earliest
      if (set_count == 0 || d < best_dist) begin
        best_dist = d;
        best_pos  = set_count;
        best_pt   = '{x, y, z};
      end
      if (set_count < MAX_POINTS - 1) set_count++;
      if (last) begin
        beat.index   = IDX_W'(best_pos);
        beat.x       = best_pt[0];
        beat.y       = best_pt[1];
        beat.z       = best_pt[2];
        beat.dist_sq = best_dist;
        pending_best.push_back(beat);
        sets_closed++;
        clear_set();
      end
    endfunction

    function int pending();
      return pending_best.size();
    endfunction

    function void check_result(best_beat_t got);
      best_beat_t want;
      if (pending_best.size() == 0) begin
        $error("result beat with no set closed: best_index %0d", got.index);
        errors++;
        return;
      end
      want = pending_best.pop_front();
      results_checked++;
      if (got.index !== want.index) begin
        $error("best_index: expected %0d, got %0d", want.index, got.index);
        errors++;
      end
      if (got.x !== want.x) begin
        $error("best_x: expected %h, got %h", want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $error("best_y: expected %h, got %h", want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $error("best_z: expected %h, got %h", want.z, got.z);
        errors++;
      end
      if (got.dist_sq !== want.dist_sq) begin
        $error("best_dist_sq: expected %h, got %h", want.dist_sq, got.dist_sq);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic                      in_last_point = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [IDX_W-1:0]          out_best_index;
  logic signed [COORD_W-1:0] out_best_x;
  logic signed [COORD_W-1:0] out_best_y;
  logic signed [COORD_W-1:0] out_best_z;
  logic [DIST_W-1:0]         out_best_dist_sq;

  nearest_scoreboard  board;
  int unsigned        cycle_count = 0;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        line_settings = 0;
  logic [COORD_W-1:0] prev_x = '0;
  logic [COORD_W-1:0] prev_y = '0;
  logic [COORD_W-1:0] prev_z = '0;

  nearest_point_to_ray_picker dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_index   (out_best_index),
    .out_best_x       (out_best_x),
    .out_best_y       (out_best_y),
    .out_best_z       (out_best_z),
    .out_best_dist_sq (out_best_dist_sq)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check each beat, stall at random
  always @(posedge clk) begin
    best_beat_t got;
    if (out_valid && out_ready) begin
      got.index   = out_best_index;
      got.x       = out_best_x;
      got.y       = out_best_y;
      got.z       = out_best_z;
      got.dist_sq = out_best_dist_sq;
      board.check_result(got);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic longint rnd_off(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return '1;
      default: return 32'd1;
    endcase
  endfunction

  // one point beat, with random idle cycles ahead of it
  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] z, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_point_x    <= x;
    in_point_y    <= y;
    in_point_z    <= z;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    board.note_point(x, y, z, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic write_line(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy,
                            logic [COORD_W-1:0] oz, logic [COORD_W-1:0] dx,
                            logic [COORD_W-1:0] dy, logic [COORD_W-1:0] dz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    cfg_we <= 1'b0;
    line_settings++;
  endtask

  // wait for every owed beat, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
      default: begin send_idle_pct = 9; recv_stall_pct = 9; end
    endcase
  endtask

  // half the points near the line, the rest repeats, extremes and noise
  task automatic pick_point(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
                            output logic [COORD_W-1:0] z);
    int unsigned kind;
    longint      s;
    longint      span;
    kind = $urandom_range(99);
    if (kind < 50) begin
      s    = rnd_off(longint'(1) << 19);
      span = $urandom_range(1) ? 16 : 65536;
      x = 32'(board.line_org[0] + ((s * board.line_dir[0]) >>> 16) + rnd_off(span));
      y = 32'(board.line_org[1] + ((s * board.line_dir[1]) >>> 16) + rnd_off(span));
      z = 32'(board.line_org[2] + ((s * board.line_dir[2]) >>> 16) + rnd_off(span));
    end else if (kind < 65) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else if (kind < 75) begin
      x = prev_x;
      y = prev_y;
      z = prev_z;
    end else if (kind < 85) begin
      x = pick_extreme();
      y = pick_extreme();
      z = pick_extreme();
    end else begin
      x = 32'(rnd_off(longint'(1) << 20));
      y = 32'(rnd_off(longint'(1) << 20));
      z = 32'(rnd_off(longint'(1) << 20));
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
  endtask

  // a different line for each random phase, extremes among them
  task automatic program_line(int k);
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] oz;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] dz;
    if (k % 3 == 0) begin
      ox = $urandom;
      oy = $urandom;
      oz = $urandom;
    end else begin
      ox = 32'(rnd_off(longint'(1) << 24));
      oy = 32'(rnd_off(longint'(1) << 24));
      oz = 32'(rnd_off(longint'(1) << 24));
    end
    case (k % 8)
      0: begin dx = ONE_Q16;       dy = '0;            dz = '0;            end
      1: begin dx = '0;            dy = -ONE_Q16;      dz = '0;            end
      2: begin dx = 32'd46341;     dy = 32'd46341;     dz = '0;            end
      3: begin dx = 32'd37837;     dy = -32'd37837;    dz = 32'd37837;     end
      4: begin dx = '0;            dy = '0;            dz = '0;            end
      5: begin dx = 32'(rnd_off(131072)); dy = 32'(rnd_off(131072));
               dz = 32'(rnd_off(131072)); end
      6: begin dx = 32'd131071;    dy = -32'd131072;   dz = 32'd131071;    end
      default: begin dx = $urandom; dy = $urandom;     dz = $urandom;      end
    endcase
    if (k % 2 == 1) begin
      write_reg(CFG_UNUSED_LO, $urandom);
      write_reg(CFG_UNUSED_HI, $urandom);
    end
    write_line(ox, oy, oz, dx, dy, dz);
  endtask

  initial begin
    int unsigned        n;
    int unsigned        set_len;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;

    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset line along z: a lone point, then extremes, a tie and a later winner
    set_idling(0);
    send_point('0, '0, '0, 1'b1);
    send_point(ONE_Q16, 32'h0002_0000, COORD_MAX, 1'b0);
    send_point(ONE_Q16, 32'h0002_0000, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b0);
    send_point('1, 32'd1, 32'h1234_5678, 1'b0);
    send_point(COORD_MIN, COORD_MIN, '0, 1'b1);

    // extreme origin and non-unit direction: saturated distances
    settle();
    write_line(COORD_MIN, COORD_MAX, COORD_MIN, 32'd131071, -32'd131072, '0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);

    // zero direction: distance to the origin, spare indexes ignored
    settle();
    write_reg(CFG_UNUSED_LO, $urandom);
    write_reg(CFG_UNUSED_HI, $urandom);
    write_line(32'h0003_0000, -ONE_Q16, '0, '0, '0, '0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(32'h0003_0000, -ONE_Q16, '0, 1'b0);
    send_point(32'h0003_0001, -ONE_Q16, 32'd1, 1'b1);

    // random sets under several lines and idling patterns
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      settle();
      program_line(k);
      set_idling(k % 4);
      n = 0;
      while (n < PHASE_POINTS) begin
        set_len = $urandom_range(1, 12);
        for (int j = 0; j < set_len; j++) begin
          pick_point(px, py, pz);
          send_point(px, py, pz, j == set_len - 1);
          n++;
        end
      end
    end

    // drain
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points in %0d sets under %0d line settings, %0d result beats checked",
             board.points_noted, board.sets_closed, line_settings, board.results_checked);
    $display("%0d mismatches", board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/npr_pkg.sv
rtl/core/npr_front.sv
rtl/core/npr_fifo.sv
rtl/core/npr_back.sv
rtl/core/nearest_point_to_ray_picker.sv
tb/nearest_point_to_ray_picker_tb.sv
